@@ rtl/core/ir_capture_quality_classifier_core_assert.svh @@
// Assertion macros used by the checker file of the capture quality core.
`ifndef IR_CAPTURE_QUALITY_CLASSIFIER_CORE_ASSERT_SVH
`define IR_CAPTURE_QUALITY_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define ICQC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("icqc assertion failed");

// Next-cycle implication, switched off while reset is held.
`define ICQC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("icqc assertion failed");

`endif

@@ rtl/core/icqc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package icqc_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int US_W        = 16;
    localparam int TICKS_W     = 16;
    localparam int CODE_W      = 64;
    localparam int PCLASS_W    = 3;
    localparam int MIN_LEN_W   = 11;
    localparam int RATIO_W     = 9;
    localparam int QUALITY_W   = 7;
    localparam int CARRIER_W   = 6;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_FRAME_LENGTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_RATIO_Q8   = 4'd1;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 11'd20;
    localparam logic [RATIO_W-1:0]   RATIO_RESET   = 9'd26;

    localparam logic [PCLASS_W-1:0] PCLASS_UNKNOWN      = 3'd0;
    localparam logic [PCLASS_W-1:0] PCLASS_SHORT_REPEAT = 3'd1;
    localparam logic [PCLASS_W-1:0] PCLASS_40K          = 3'd2;
    localparam logic [PCLASS_W-1:0] PCLASS_36K          = 3'd3;

    localparam logic [US_W-1:0]  OUTLIER_MIN_US = 16'd100;
    localparam logic [CNT_W-1:0] WINDOW_MIN_K   = CNT_W'(3);
    localparam logic [CNT_W-1:0] NOISE_MIN_LEN  = CNT_W'(10);
    localparam logic [CNT_W-1:0] REPEAT_MAX_LEN = CNT_W'(10);

    localparam logic [QUALITY_W-1:0] QUALITY_BASE     = 7'd100;
    localparam logic [QUALITY_W-1:0] PENALTY_SHORT    = 7'd30;
    localparam logic [QUALITY_W-1:0] PENALTY_UNKNOWN  = 7'd10;
    localparam logic [QUALITY_W-1:0] PENALTY_NOISY    = 7'd20;
    localparam logic [QUALITY_W-1:0] PENALTY_ZERO_VAL = 7'd15;

    localparam logic [CARRIER_W-1:0] CARRIER_40K = 6'd40;
    localparam logic [CARRIER_W-1:0] CARRIER_36K = 6'd36;
    localparam logic [CARRIER_W-1:0] CARRIER_38K = 6'd38;

    localparam logic [CODE_W-1:0] CODE_ONES_32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [CODE_W-1:0] CODE_ONES_64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [CNT_W-1:0] frame_length;
        logic [CNT_W-1:0] outlier_count;
    } frame_sum_t;

    typedef struct packed {
        logic [CARRIER_W-1:0] carrier_khz;
        logic                 is_repeat;
        logic                 noisy;
        logic                 too_short;
        logic [CNT_W-1:0]     frame_length;
        logic [CNT_W-1:0]     outlier_count;
        logic [QUALITY_W-1:0] quality_score;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/ir_capture_quality_classifier_core.sv @@
// The result appears on the master side in the cycle after the sample marked last is accepted.
// Throughput: one sample per cycle while the slave side is not stalled; the frame window and the
// grading sit between the window registers and the single result register.
// The slave side stalls only while a result waits in the result register and is not taken.
// Reset (aresetn low, synchronous) clears the window state and the result valid flag and
// restores the threshold registers to 20 samples and 26/256.
`timescale 1ns / 1ps
`default_nettype none

module ir_capture_quality_classifier_core #(
    parameter int TICK_US = 2
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [79:0]  s_tdata,   // sample_ticks[15:0], code_value[79:16]
    input  wire         s_tlast,
    input  wire [2:0]   s_tuser,   // protocol_class[2:0]

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // quality_score[6:0], outlier_count[17:7],
                                   // frame_length[28:18], too_short[29], noisy[30],
                                   // is_repeat[31], carrier_khz[37:32], zero[39:38]

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [icqc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [icqc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [icqc_pkg::MIN_LEN_W-1:0] min_len_reg;
    logic [icqc_pkg::RATIO_W-1:0]   ratio_reg;
    logic                           m_valid_reg, m_valid_next;
    icqc_pkg::result_t              result_reg;
    icqc_pkg::result_t              result_next;
    icqc_pkg::frame_sum_t           frame_sum;
    logic                           s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    icqc_window #(
        .TICK_US (TICK_US)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .sample_ticks (s_tdata[15:0]),
        .last_sample  (s_tlast),
        .frame_sum    (frame_sum)
    );

    icqc_grade u_grade (
        .frame_sum        (frame_sum),
        .min_frame_length (min_len_reg),
        .noise_ratio_q8   (ratio_reg),
        .protocol_class   (s_tuser),
        .code_value       (s_tdata[79:16]),
        .result           (result_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) m_valid_next = 1'b0;
        if (s_accept && s_tlast) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= icqc_pkg::MIN_LEN_RESET;
            ratio_reg   <= icqc_pkg::RATIO_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    icqc_pkg::REG_MIN_FRAME_LENGTH: min_len_reg <= cfg_data;
                    icqc_pkg::REG_NOISE_RATIO_Q8:   ratio_reg <= cfg_data[icqc_pkg::RATIO_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, result_reg};

endmodule

`default_nettype wire

@@ rtl/core/icqc_window.sv @@
`timescale 1ns / 1ps
`default_nettype none

module icqc_window #(
    parameter int TICK_US = 2
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             accept,
    input  wire [icqc_pkg::TICKS_W-1:0]     sample_ticks,
    input  wire                             last_sample,
    output icqc_pkg::frame_sum_t            frame_sum
);

    logic [icqc_pkg::US_W-1:0]  older_reg, older_next;
    logic [icqc_pkg::US_W-1:0]  center_reg, center_next;
    logic [icqc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [icqc_pkg::CNT_W-1:0] outl_reg, outl_next;
    logic [icqc_pkg::US_W-1:0]  cur_us;
    logic [icqc_pkg::US_W-1:0]  diff_old, diff_cur;
    logic [icqc_pkg::CNT_W-1:0] count_sat;
    logic                       outlier_hit;

    assign cur_us = icqc_pkg::US_W'(32'(sample_ticks) * TICK_US);

    always_comb begin
        diff_old = (center_reg > older_reg) ? center_reg - older_reg : older_reg - center_reg;
        diff_cur = (center_reg > cur_us) ? center_reg - cur_us : cur_us - center_reg;
        outlier_hit = !last_sample && (count_reg >= icqc_pkg::WINDOW_MIN_K)
                      && (center_reg > icqc_pkg::OUTLIER_MIN_US)
                      && ({diff_old, 1'b0} > {1'b0, center_reg})
                      && ({diff_cur, 1'b0} > {1'b0, center_reg});
        count_sat = (count_reg < icqc_pkg::CNT_W'(icqc_pkg::MAX_SAMPLES))
                    ? count_reg + 1'b1 : count_reg;

        older_next  = older_reg;
        center_next = center_reg;
        count_next  = count_reg;
        outl_next   = outl_reg;
        if (accept) begin
            if (last_sample) begin
                older_next  = '0;
                center_next = '0;
                count_next  = '0;
                outl_next   = '0;
            end else begin
                older_next  = center_reg;
                center_next = cur_us;
                count_next  = count_sat;
                if (outlier_hit && (outl_reg < icqc_pkg::CNT_W'(icqc_pkg::MAX_SAMPLES))) begin
                    outl_next = outl_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg  <= '0;
            center_reg <= '0;
            count_reg  <= '0;
            outl_reg   <= '0;
        end else begin
            older_reg  <= older_next;
            center_reg <= center_next;
            count_reg  <= count_next;
            outl_reg   <= outl_next;
        end
    end

    // The final sample is never a window centre, so the outlier count is already complete.
    assign frame_sum.frame_length  = count_sat;
    assign frame_sum.outlier_count = outl_reg;

endmodule

`default_nettype wire

@@ rtl/core/icqc_grade.sv @@
`timescale 1ns / 1ps
`default_nettype none

module icqc_grade (
    input  icqc_pkg::frame_sum_t                frame_sum,
    input  wire [icqc_pkg::MIN_LEN_W-1:0]       min_frame_length,
    input  wire [icqc_pkg::RATIO_W-1:0]         noise_ratio_q8,
    input  wire [icqc_pkg::PCLASS_W-1:0]        protocol_class,
    input  wire [icqc_pkg::CODE_W-1:0]          code_value,
    output icqc_pkg::result_t                   result
);

    localparam int PROD_W = icqc_pkg::RATIO_W + icqc_pkg::CNT_W;

    logic [icqc_pkg::CNT_W-1:0]     len;
    logic [icqc_pkg::CNT_W-1:0]     outl;
    logic                           long_frame;
    logic                           unknown;
    logic                           code_zero;
    logic [PROD_W-1:0]              limit;
    logic [PROD_W-1:0]              scaled;
    logic [icqc_pkg::QUALITY_W-1:0] q;

    always_comb begin
        len        = frame_sum.frame_length;
        long_frame = len > icqc_pkg::NOISE_MIN_LEN;
        outl       = long_frame ? frame_sum.outlier_count : '0;
        unknown    = protocol_class == icqc_pkg::PCLASS_UNKNOWN;
        code_zero  = code_value == '0;
        limit      = PROD_W'(noise_ratio_q8) * PROD_W'(len);
        scaled     = PROD_W'({outl, 8'b0});

        result.frame_length  = len;
        result.outlier_count = outl;
        result.too_short     = PROD_W'(len) < PROD_W'(min_frame_length);
        result.noisy         = long_frame && (scaled > limit);
        result.is_repeat     = ((protocol_class == icqc_pkg::PCLASS_SHORT_REPEAT)
                                && (len < icqc_pkg::REPEAT_MAX_LEN))
                               || (code_value == icqc_pkg::CODE_ONES_32)
                               || (code_value == icqc_pkg::CODE_ONES_64);

        q = icqc_pkg::QUALITY_BASE;
        if (result.too_short) q = q - icqc_pkg::PENALTY_SHORT;
        if (unknown) q = q - icqc_pkg::PENALTY_UNKNOWN;
        if (result.noisy) q = q - icqc_pkg::PENALTY_NOISY;
        if (!unknown && code_zero) q = q - icqc_pkg::PENALTY_ZERO_VAL;
        result.quality_score = q;

        case (protocol_class)
            icqc_pkg::PCLASS_40K: result.carrier_khz = icqc_pkg::CARRIER_40K;
            icqc_pkg::PCLASS_36K: result.carrier_khz = icqc_pkg::CARRIER_36K;
            default:              result.carrier_khz = icqc_pkg::CARRIER_38K;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/icqc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "ir_capture_quality_classifier_core_assert.svh"

module icqc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        s_tlast,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata
);

    logic [6:0] score;
    logic [5:0] carrier;
    logic       score_ok;
    logic       carrier_ok;
    logic       s_last_accept;

    assign score         = m_tdata[6:0];
    assign carrier       = m_tdata[37:32];
    assign score_ok      = (score >= 7'd25) && (score <= 7'd100);
    assign carrier_ok    = (carrier == 6'd36) || (carrier == 6'd38) || (carrier == 6'd40);
    assign s_last_accept = s_tvalid && s_tready && s_tlast;

    `ICQC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ICQC_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, s_last_accept, m_tvalid)
    `ICQC_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)
    `ICQC_ASSERT_IMPL(a_score_range, aclk, aresetn, m_tvalid, score_ok)
    `ICQC_ASSERT_IMPL(a_carrier_code, aclk, aresetn, m_tvalid, carrier_ok)

endmodule

bind ir_capture_quality_classifier_core icqc_checker u_icqc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
